// ===== sv/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrt_pkg: shared types and constants for the memory region table
// Command codes, status codes and the per-cell command word.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int unsigned DefMaxEntries = 64;
  localparam int unsigned IdxW = 6;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_MERGE  = 3'd2,
    CMD_SPLIT  = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // control sequencer states
  typedef enum logic [1:0] { S_IDLE, S_EXEC, S_SHIFT } st_t;

  // one region record
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [7:0]  kind;
  } region_t;

  // per-cycle action broadcast to every cell
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_SHIFT_UP,
    ACT_SHIFT_DOWN,
    ACT_WRITE,
    ACT_SPLIT
  } act_t;

  typedef struct packed {
    act_t        act;
    logic [15:0] lo;     // first affected index
    region_t     wr;     // record written at lo
    region_t     wr2;    // record written at lo + 1 (split)
  } cell_ctl_t;

endpackage

// ===== sv/mrt_cell.sv =====
// ----------------------------------------------------------------------------
// mrt_cell: one table slot
// Holds one region record, moves with its neighbours and flags lookup hits.
// ----------------------------------------------------------------------------
module mrt_cell
  import mrt_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic          clk,
  input  logic [AW-1:0] my_index,
  input  cell_ctl_t     ctl,
  input  region_t       from_below,
  input  region_t       from_above,
  input  logic [63:0]   addr,
  output region_t       rec,
  output logic          hit_contain,
  output logic          hit_follow
);

  logic [15:0] idx16;
  logic [63:0] diff;
  region_t rec_next;

  assign idx16 = 16'(my_index);

  // next record from the broadcast action
  always_comb begin
    rec_next = rec;
    case (ctl.act)
      ACT_SHIFT_UP: begin
        if (idx16 == ctl.lo) rec_next = ctl.wr;
        else if (idx16 > ctl.lo) rec_next = from_below;
      end
      ACT_SHIFT_DOWN: begin
        if (idx16 >= ctl.lo) rec_next = from_above;
      end
      ACT_WRITE: begin
        if (idx16 == ctl.lo) rec_next = ctl.wr;
      end
      ACT_SPLIT: begin
        if (idx16 == ctl.lo) rec_next = ctl.wr;
        else if (idx16 == ctl.lo + 16'd1) rec_next = ctl.wr2;
        else if (idx16 > ctl.lo + 16'd1) rec_next = from_below;
      end
      default: rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

  // lookup compares
  assign diff        = addr - rec.base;
  assign hit_contain = (addr >= rec.base) && (diff < rec.size);
  assign hit_follow  = rec.base > addr;

endmodule

// ===== sv/memory_region_table.sv =====
// ----------------------------------------------------------------------------
// memory_region_table: ordered table of memory regions in a chain of cells
// sequence: a command is latched when taken and executed in the execute state, which
//   waits while the result register is stalled; remove, multi-entry merge and a
//   whole-entry split then shift entries down; in_stall is high until idle again
// reset: synchronous, clears the count, control and result valid; records undefined
// ----------------------------------------------------------------------------
module memory_region_table
  import mrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DefMaxEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [5:0]  first_index,
  input  logic [5:0]  last_index,
  input  logic [63:0] entry_base,
  input  logic [63:0] entry_size,
  input  logic [7:0]  entry_type,
  input  logic [63:0] split_offset,
  input  logic [63:0] lookup_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  region_count,
  output logic [1:0]  status,
  output logic [5:0]  containing_index,
  output logic        containing_found,
  output logic [5:0]  following_index,
  output logic        following_found
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [15:0] MaxE = 16'(MAX_ENTRIES);

  st_t state, state_next;

  // latched command word
  logic [2:0]  c_cmd;
  logic [15:0] c_first, c_last;
  region_t     c_ent;
  logic [63:0] c_off, c_addr;
  logic [15:0] count;
  logic [15:0] left;  // remaining downward shifts
  logic        out_full;
  logic        go;     // result register free to take a new word

  // cell array
  region_t recs [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hc, hf;
  cell_ctl_t ctl;
  region_t   blank;
  assign blank = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      region_t below, above;
      if (g == 0) begin : g_lo
        assign below = blank;
      end else begin : g_lo
        assign below = recs[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_hi
        assign above = blank;
      end else begin : g_hi
        assign above = recs[g+1];
      end
      mrt_cell #(.AW(AW)) u_cell (
        .clk(clk), .my_index(AW'(g)), .ctl(ctl),
        .from_below(below), .from_above(above), .addr(c_addr),
        .rec(recs[g]), .hit_contain(hc[g]), .hit_follow(hf[g])
      );
    end
  endgenerate

  // first-hit encoders over valid cells
  logic [AW-1:0] ci, fi;
  logic cf, ff;
  always_comb begin
    ci = '0; fi = '0; cf = 1'b0; ff = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (16'(i) < count && hc[i]) begin ci = AW'(i); cf = 1'b1; end
      if (16'(i) < count && hf[i]) begin fi = AW'(i); ff = 1'b1; end
    end
  end

  // record reads for merge and split
  region_t rf, rl;
  logic [63:0] tail_s;
  assign rf = recs[c_first[AW-1:0]];
  assign rl = recs[c_last[AW-1:0]];
  assign tail_s = rf.size - c_off;

  assign go = !out_full || !out_stall;

  // decision in the execute cycle; downward shift action in the shift state
  logic [1:0]  st_calc;
  logic        need_shift;
  logic [15:0] cnt_calc;
  always_comb begin
    ctl = '0;
    ctl.act = ACT_HOLD;
    st_calc = ST_OK;
    need_shift = 1'b0;
    cnt_calc = count;
    if (state == S_SHIFT) begin
      ctl.act = ACT_SHIFT_DOWN;
      ctl.lo = c_first;
    end else if (state == S_EXEC && go) begin
      case (c_cmd)
        CMD_INSERT: begin
          if (count >= MaxE) st_calc = ST_FULL;
          else if (c_first > count) st_calc = ST_BAD;
          else begin
            ctl.act = ACT_SHIFT_UP; ctl.lo = c_first; ctl.wr = c_ent;
            cnt_calc = count + 16'd1;
          end
        end
        CMD_REMOVE, CMD_MERGE: begin
          if (c_first > c_last || c_last >= count) st_calc = ST_BAD;
          else if (c_cmd == CMD_MERGE) begin
            ctl.act = ACT_WRITE; ctl.lo = c_first;
            ctl.wr.base = rf.base;
            ctl.wr.size = rl.base + rl.size - rf.base;
            ctl.wr.kind = rf.kind;
            need_shift = (c_last != c_first);
            cnt_calc = count - (c_last - c_first);
          end else begin
            need_shift = 1'b1;
            cnt_calc = count - (c_last - c_first) - 16'd1;
          end
        end
        CMD_SPLIT: begin
          if (c_first >= count) st_calc = ST_BAD;
          else if (c_off > rf.size || c_ent.size > tail_s) st_calc = ST_BAD;
          else if (c_off == '0 && c_ent.size == rf.size) begin
            need_shift = 1'b1; cnt_calc = count - 16'd1;
          end else if (c_off == '0) begin
            ctl.act = ACT_WRITE; ctl.lo = c_first;
            ctl.wr.base = rf.base + c_ent.size;
            ctl.wr.size = rf.size - c_ent.size;
            ctl.wr.kind = rf.kind;
          end else if (c_ent.size == tail_s) begin
            ctl.act = ACT_WRITE; ctl.lo = c_first;
            ctl.wr = rf; ctl.wr.size = c_off;
          end else if (count >= MaxE) st_calc = ST_FULL;
          else begin
            ctl.act = ACT_SPLIT; ctl.lo = c_first;
            ctl.wr = rf; ctl.wr.size = c_off;
            ctl.wr2.base = rf.base + c_off + c_ent.size;
            ctl.wr2.size = tail_s - c_ent.size;
            ctl.wr2.kind = rf.kind;
            cnt_calc = count + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  if (go) state_next = need_shift ? S_SHIFT : S_IDLE;
      S_SHIFT: if (left == 16'd1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      left     <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && go) begin
        count    <= cnt_calc;
        out_full <= 1'b1;
        // merge keeps first slot, so shift the rest one place above it
        if (c_cmd == CMD_MERGE) left <= c_last - c_first;
        else left <= c_last - c_first + 16'd1;
      end else begin
        if (!out_stall) out_full <= 1'b0;
        if (state == S_SHIFT) left <= left - 16'd1;
      end
    end
  end

  // command and result words
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      c_cmd   <= cmd;
      c_first <= 16'(first_index);
      c_last  <= (cmd == CMD_SPLIT) ? 16'(first_index) : 16'(last_index);
      c_ent   <= '{base: entry_base, size: entry_size, kind: entry_type};
      c_off   <= split_offset;
      c_addr  <= lookup_address;
    end
    if (state == S_EXEC && go) begin
      // merge shifting starts one above first
      if (c_cmd == CMD_MERGE) c_first <= c_first + 16'd1;
      status           <= st_calc;
      region_count     <= 7'(cnt_calc);
      containing_index <= (c_cmd == CMD_LOOKUP) ? 6'(ci) : '0;
      containing_found <= (c_cmd == CMD_LOOKUP) && cf;
      following_index  <= (c_cmd == CMD_LOOKUP) ? 6'(fi) : '0;
      following_found  <= (c_cmd == CMD_LOOKUP) && ff;
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the memory region table
// Drives directed and random commands through the valid/stall handshake,
// predicts every result word from a local copy of the table and compares
// each returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb
  import mrt_pkg::*;
();

  localparam int Depth = 64;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [6:0] count;
    logic [1:0] st;
    logic [5:0] cidx;
    logic       cfound;
    logic [5:0] fidx;
    logic       ffound;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = '0;
  logic [5:0]  first_index = '0;
  logic [5:0]  last_index = '0;
  logic [63:0] entry_base = '0;
  logic [63:0] entry_size = '0;
  logic [7:0]  entry_type = '0;
  logic [63:0] split_offset = '0;
  logic [63:0] lookup_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  region_count;
  logic [1:0]  status;
  logic [5:0]  containing_index;
  logic        containing_found;
  logic [5:0]  following_index;
  logic        following_found;

  // local copy of the table
  region_t tbl [Depth];
  int      tbl_count;
  word_t   pending_words [$];
  int      errors;
  int      cycles;
  bit      rx_stall_en;

  memory_region_table dut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // shift entries [from, count) to start at dst
  function automatic void move_entries(int dst, int from);
    int i;
    if (dst > from) begin
      for (i = tbl_count - 1; i >= from; i--) tbl[i + dst - from] = tbl[i];
    end else begin
      for (i = from; i < tbl_count; i++) tbl[i - from + dst] = tbl[i];
    end
  endfunction

  function automatic void put_region(int idx, region_t r);
    if (tbl_count > idx) move_entries(idx + 1, idx);
    tbl[idx] = r;
    tbl_count++;
  endfunction

  function automatic void drop_regions(int lo, int hi);
    if (tbl_count > hi + 1) move_entries(lo, hi + 1);
    tbl_count -= hi - lo + 1;
  endfunction

  // predict the result word of one command and update the table copy
  function automatic word_t table_update(logic [2:0] c, int fi, int li, logic [63:0] eb,
                                         logic [63:0] es, logic [7:0] et,
                                         logic [63:0] off, logic [63:0] addr);
    word_t w;
    region_t r;
    logic [63:0] b, s, e;
    int i;
    w = '0;
    w.st = ST_OK;
    case (c)
      CMD_INSERT: begin
        if (tbl_count >= Depth) w.st = ST_FULL;
        else if (fi > tbl_count) w.st = ST_BAD;
        else begin
          r.base = eb; r.size = es; r.kind = et;
          put_region(fi, r);
        end
      end
      CMD_REMOVE, CMD_MERGE: begin
        if (fi > li || li >= tbl_count) w.st = ST_BAD;
        else if (c == CMD_REMOVE) drop_regions(fi, li);
        else begin
          r = tbl[fi];
          e = tbl[li].base + tbl[li].size;
          r.size = e - r.base;
          drop_regions(fi, li);
          put_region(fi, r);
        end
      end
      CMD_SPLIT: begin
        if (fi >= tbl_count) w.st = ST_BAD;
        else begin
          b = tbl[fi].base;
          s = tbl[fi].size;
          if (off > s || es > s - off) w.st = ST_BAD;
          else if (off == 0 && es == s) drop_regions(fi, fi);
          else if (off == 0) begin
            tbl[fi].base = b + es;
            tbl[fi].size = s - es;
          end else if (off + es == s) tbl[fi].size = s - es;
          else if (tbl_count >= Depth) w.st = ST_FULL;
          else begin
            tbl[fi].size = off;
            r.base = b + off + es; r.size = s - off - es; r.kind = tbl[fi].kind;
            put_region(fi + 1, r);
          end
        end
      end
      CMD_LOOKUP: begin
        for (i = 0; i < tbl_count; i++)
          if (!w.cfound && addr >= tbl[i].base && addr - tbl[i].base < tbl[i].size) begin
            w.cidx = i[5:0];
            w.cfound = 1'b1;
          end
        for (i = 0; i < tbl_count; i++)
          if (!w.ffound && tbl[i].base > addr) begin
            w.fidx = i[5:0];
            w.ffound = 1'b1;
          end
      end
      default: ;
    endcase
    w.count = tbl_count[6:0];
    return w;
  endfunction

  // send one command word and record its prediction
  task automatic send_word(logic [2:0] c, int fi, int li, logic [63:0] eb,
                           logic [63:0] es, logic [7:0] et, logic [63:0] off,
                           logic [63:0] addr);
    int g;
    g = gap_len();
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    first_index <= fi[5:0];
    last_index <= li[5:0];
    entry_base <= eb;
    entry_size <= es;
    entry_type <= et;
    split_offset <= off;
    lookup_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_words.push_back(table_update(c, fi, li, eb, es, et, off, addr));
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int g;
    forever begin
      g = rx_stall_en ? gap_len() : 0;
      if (g != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    word_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        x = pending_words.pop_front();
        if (region_count !== x.count) begin
          $error("region_count exp %0d got %0d", x.count, region_count); errors++;
        end
        if (status !== x.st) begin
          $error("status exp %0d got %0d", x.st, status); errors++;
        end
        if (containing_index !== x.cidx) begin
          $error("containing_index exp %0d got %0d", x.cidx, containing_index); errors++;
        end
        if (containing_found !== x.cfound) begin
          $error("containing_found exp %0d got %0d", x.cfound, containing_found); errors++;
        end
        if (following_index !== x.fidx) begin
          $error("following_index exp %0d got %0d", x.fidx, following_index); errors++;
        end
        if (following_found !== x.ffound) begin
          $error("following_found exp %0d got %0d", x.ffound, following_found); errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'(($urandom_range(0, 15)));
      default: return rand64();
    endcase
  endfunction

  // directed: extremes, every command and the listed corner cases
  task automatic test_directed();
    send_word(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0);              // empty table
    send_word(CMD_INSERT, 1, 0, 0, 0, 0, 0, 0);              // index above count
    send_word(CMD_INSERT, 0, 0, 64'h1000, 64'h100, 8'hFF, 0, 0);
    send_word(CMD_INSERT, 1, 0, 64'h2000, 64'h100, 8'h01, 0, 0);
    send_word(CMD_INSERT, 0, 0, '1, '1, 8'h00, 0, 0);        // at front
    send_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 64'h1080);
    send_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, '1);
    send_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 64'h0);
    send_word(CMD_MERGE, 2, 1, 0, 0, 0, 0, 0);               // first > last
    send_word(CMD_MERGE, 1, 2, 0, 0, 0, 0, 0);
    send_word(CMD_SPLIT, 1, 0, 0, 64'h10, 0, 64'h20, 0);    // cut in two
    send_word(CMD_SPLIT, 1, 0, 0, 64'h10, 0, 0, 0);         // trim front
    send_word(CMD_SPLIT, 2, 0, 0, 64'h10, 0, 64'h10c0, 0);  // trim back
    send_word(CMD_SPLIT, 1, 0, 0, 64'h1, 0, '1, 0);         // offset beyond size
    send_word(CMD_SPLIT, 5, 0, 0, 0, 0, 0, 0);              // index beyond count
    send_word(CMD_SPLIT, 0, 0, 0, '1, 0, 0, 0);             // remove whole
    send_word(3'd5, 63, 63, '1, '1, '1, '1, '1);             // unknown commands
    send_word(3'd7, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REMOVE, 0, 63, 0, 0, 0, 0, 0);             // last beyond count
    send_word(CMD_REMOVE, 0, tbl_count - 1, 0, 0, 0, 0, 0);
    // fill to full, then full-table cases
    while (tbl_count < Depth)
      send_word(CMD_INSERT, tbl_count, 0, 64'(tbl_count) << 12, 64'h800, 8'(tbl_count), 0, 0);
    send_word(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_SPLIT, 63, 0, 0, 64'h10, 0, 64'h10, 0);
    send_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 64'h3F800);
    send_word(CMD_REMOVE, 0, 63, 0, 0, 0, 0, 0);
  endtask

  // random: mostly well-formed commands on a populated table
  task automatic test_random(int n);
    int k, c, fi, li;
    logic [63:0] s, off, hs, a;
    for (k = 0; k < n; k++) begin
      c = $urandom_range(0, 99);
      if (c < 8) begin
        send_word(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom_range(0, 63),
                  rand64(), edge64(), 8'($urandom()), edge64(), edge64());
      end else if (c < 40 || tbl_count < 2) begin
        fi = $urandom_range(0, tbl_count);
        send_word(CMD_INSERT, fi, $urandom_range(0, 63), edge64(), edge64(),
                  8'($urandom()), rand64(), rand64());
      end else if (c < 50 && tbl_count > 0) begin
        fi = $urandom_range(0, tbl_count - 1);
        li = fi + $urandom_range(0, (tbl_count - 1 - fi) < 3 ? tbl_count - 1 - fi : 3);
        send_word(CMD_REMOVE, fi, li, rand64(), rand64(), 8'($urandom()), rand64(), rand64());
      end else if (c < 58 && tbl_count > 0) begin
        fi = $urandom_range(0, tbl_count - 1);
        li = $urandom_range(fi, tbl_count - 1);
        send_word(CMD_MERGE, fi, li, rand64(), rand64(), 8'($urandom()), rand64(), rand64());
      end else if (c < 80 && tbl_count > 0) begin
        fi = $urandom_range(0, tbl_count - 1);
        s = tbl[fi].size;
        case ($urandom_range(0, 4))
          0: begin off = 0; hs = s; end
          1: begin off = 0; hs = s == 0 ? 0 : rand64() % s; end
          2: begin hs = s == 0 ? 0 : rand64() % s; off = s - hs; end
          3: begin off = s == 0 ? 0 : rand64() % s; hs = (s - off) == 0 ? 0 : rand64() % (s - off); end
          default: begin off = edge64(); hs = edge64(); end
        endcase
        send_word(CMD_SPLIT, fi, $urandom_range(0, 63), rand64(), hs, 8'($urandom()), off,
                  rand64());
      end else begin
        a = tbl_count > 0 ? tbl[$urandom_range(0, tbl_count - 1)].base + 64'($urandom_range(0, 3)) - 1
                          : edge64();
        if ($urandom_range(0, 3) == 0) a = edge64();
        send_word(CMD_LOOKUP, $urandom_range(0, 63), $urandom_range(0, 63), rand64(), rand64(),
                  8'($urandom()), rand64(), a);
      end
    end
  endtask

  // pause until the table has drained every pending word
  task automatic test_drain_pause();
    while (pending_words.size() != 0) @(posedge clk);
    send_word(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, rand64());
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    tbl_count = 0;
    rx_stall_en = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(360);
    test_drain_pause();
    rx_stall_en = 1'b0;
    test_random(100);
    rx_stall_en = 1'b1;
    test_random(360);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
